FILE: rtl/centered_moving_average_detrend_defines.svh
// Assertion macros shared by the detrend block's modules.
`ifndef CENTERED_MOVING_AVERAGE_DETREND_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_DETREND_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define CMAD_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cmad: invariant check failed");

// When pre holds, post must hold in the next cycle.
`define CMAD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cmad: sequence check failed");

`else

`define CMAD_ASSERT(lbl, cond)
`define CMAD_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

FILE: rtl/cmad_pkg.sv
// Shared constants for the centered moving average detrend block.
package cmad_pkg;

    // Fixed field widths of the stream ports
    localparam int SAMPLE_W  = 16;
    localparam int OUT_W     = 21;
    localparam int FRAC_BITS = 4;

    // Defaults for the top-level parameters
    localparam int DEF_HALF_WINDOW = 15;
    localparam int DEF_SAMPLE_BITS = 16;

    // Depth of the job queue between window front end and divider
    localparam int QUEUE_DEPTH = 4;

endpackage

FILE: rtl/cmad_in_if.sv
// Input sample stream: valid/ready with sample and end-of-spectrum mark.
interface cmad_in_if import cmad_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                end_of_spectrum;

    modport source (output valid, output sample, output end_of_spectrum, input ready);
    modport sink   (input valid, input sample, input end_of_spectrum, output ready);
endinterface

FILE: rtl/cmad_out_if.sv
// Result stream: valid/ready with detrended value and last-sample flag.
interface cmad_out_if import cmad_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] detrended;
    logic                    final_result;

    modport source (output valid, output detrended, output final_result, input ready);
    modport sink   (input valid, input detrended, input final_result, output ready);
endinterface

FILE: rtl/cmad_front.sv
// Window front end: sample store, running sum, output scheduling and end flush.
`include "centered_moving_average_detrend_defines.svh"

module cmad_front import cmad_pkg::*; #(
    parameter int HALF_WINDOW = DEF_HALF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int WIN_LEN = 2 * HALF_WINDOW + 1,
    localparam int SB      = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W,
    localparam int CW      = $clog2(WIN_LEN + 1),
    localparam int SUMW    = SB + CW,
    localparam int JOB_W   = SB + SUMW + CW + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    cmad_in_if.sink          samples,
    output logic             job_valid,
    input  logic             job_ready,
    output logic [JOB_W-1:0] job
);

    localparam int AW = $clog2(WIN_LEN);
    localparam int PW = $clog2(HALF_WINDOW + 2);

    typedef struct packed {
        logic [SB-1:0]   x;
        logic [SUMW-1:0] sum;
        logic [CW-1:0]   cnt;
        logic            is_last;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PUSH  = 4'b0010,
        ST_FL_RD = 4'b0100,
        ST_FL_EM = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [SUMW-1:0] sum_reg, sum_next;
    logic [CW-1:0]   seen_reg, seen_next;
    logic [PW-1:0]   pend_reg, pend_next;
    logic [PW-1:0]   age_reg, age_next;
    logic [AW-1:0]   px_reg, px_next;
    logic [AW-1:0]   pd_reg, pd_next;
    logic            last_reg, last_next;
    logic [SB-1:0]   x_reg, x_next;

    // Window store, two registered read ports, one write port
    logic [SB-1:0]   store_mem [WIN_LEN];
    logic [SB-1:0]   rd_a_reg, rd_b_reg;
    logic            mem_we, mem_re;
    logic [AW-1:0]   addr_a, addr_b;

    logic [AW-1:0]   addr_h, wp_inc, px0, pd0, px_inc, pd_inc;
    logic            full, need_job, drop;
    logic [SUMW-1:0] sum_push, sum_fl;
    logic [CW-1:0]   seen_push, cnt_fl;
    logic [PW-1:0]   pend_push;
    job_t            job_d;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wp_reg] <= x_reg;
        end
        if (mem_re)
        begin
            rd_a_reg <= store_mem[addr_a];
            rd_b_reg <= store_mem[addr_b];
        end
    end

    // Circular index arithmetic
    assign addr_h = (wp_reg >= AW'(HALF_WINDOW)) ? wp_reg - AW'(HALF_WINDOW)
                                                : wp_reg + AW'(HALF_WINDOW + 1);
    assign wp_inc = (wp_reg == AW'(WIN_LEN - 1)) ? '0 : wp_reg + 1'b1;
    assign px0    = (wp_reg >= AW'(pend_reg)) ? wp_reg - AW'(pend_reg)
                                              : wp_reg + (AW'(WIN_LEN) - AW'(pend_reg));
    assign pd0    = (px0 >= AW'(HALF_WINDOW + 1)) ? px0 - AW'(HALF_WINDOW + 1)
                                                  : px0 + AW'(HALF_WINDOW);
    assign px_inc = (px_reg == AW'(WIN_LEN - 1)) ? '0 : px_reg + 1'b1;
    assign pd_inc = (pd_reg == AW'(WIN_LEN - 1)) ? '0 : pd_reg + 1'b1;

    // Push of a new sample: evict the oldest once the window is full
    assign full      = (seen_reg == CW'(WIN_LEN));
    assign sum_push  = sum_reg - (full ? SUMW'(rd_a_reg) : '0) + SUMW'(x_reg);
    assign seen_push = full ? seen_reg : seen_reg + 1'b1;
    assign pend_push = pend_reg + 1'b1;
    assign need_job  = (pend_push > PW'(HALF_WINDOW));

    // Flush: window of the sample at age_reg loses its oldest entry
    assign drop   = ((CW'(age_reg) + CW'(HALF_WINDOW + 1)) < seen_reg);
    assign sum_fl = sum_reg - (drop ? SUMW'(rd_a_reg) : '0);
    assign cnt_fl = drop ? CW'(age_reg) + CW'(HALF_WINDOW + 1) : seen_reg;

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        sum_next   = sum_reg;
        seen_next  = seen_reg;
        pend_next  = pend_reg;
        age_next   = age_reg;
        px_next    = px_reg;
        pd_next    = pd_reg;
        last_next  = last_reg;
        x_next     = x_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        addr_a     = wp_reg;
        addr_b     = addr_h;
        job_valid  = 1'b0;
        job_d      = '{x: rd_b_reg, sum: sum_push, cnt: seen_push, is_last: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    mem_re     = 1'b1;
                    x_next     = samples.sample[SB-1:0];
                    last_next  = samples.end_of_spectrum;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                job_valid = !last_reg && need_job;
                if (!(job_valid && !job_ready))
                begin
                    mem_we    = 1'b1;
                    wp_next   = wp_inc;
                    sum_next  = sum_push;
                    seen_next = seen_push;
                    if (last_reg)
                    begin
                        age_next   = pend_reg;
                        px_next    = px0;
                        pd_next    = pd0;
                        state_next = ST_FL_RD;
                    end
                    else
                    begin
                        pend_next  = need_job ? PW'(HALF_WINDOW) : pend_push;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FL_RD:
            begin
                mem_re     = 1'b1;
                addr_a     = pd_reg;
                addr_b     = px_reg;
                state_next = ST_FL_EM;
            end
            ST_FL_EM:
            begin
                job_valid = 1'b1;
                job_d     = '{x: rd_b_reg, sum: sum_fl, cnt: cnt_fl,
                              is_last: (age_reg == '0)};
                if (job_ready)
                begin
                    sum_next = sum_fl;
                    if (age_reg == '0)
                    begin
                        wp_next    = '0;
                        sum_next   = '0;
                        seen_next  = '0;
                        pend_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        age_next   = age_reg - 1'b1;
                        px_next    = px_inc;
                        pd_next    = pd_inc;
                        state_next = ST_FL_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign samples.ready = (state_reg == ST_IDLE);
    assign job           = job_d;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            sum_reg   <= '0;
            seen_reg  <= '0;
            pend_reg  <= '0;
            age_reg   <= '0;
            px_reg    <= '0;
            pd_reg    <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            sum_reg   <= sum_next;
            seen_reg  <= seen_next;
            pend_reg  <= pend_next;
            age_reg   <= age_next;
            px_reg    <= px_next;
            pd_reg    <= pd_next;
            last_reg  <= last_next;
        end
    end

    // Sample payload
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    `CMAD_ASSERT_NEXT(a_flush_clears, job_valid && job_ready && job_d.is_last, seen_reg == '0 && state_reg == ST_IDLE)
    `CMAD_ASSERT(a_pend_bound, state_reg != ST_IDLE || pend_reg <= PW'(HALF_WINDOW))

endmodule

FILE: rtl/cmad_queue.sv
// Small job queue between the window front end and the divider back end.
`include "centered_moving_average_detrend_defines.svh"

module cmad_queue import cmad_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg < CNTW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `CMAD_ASSERT(a_count_bound, count_reg <= CNTW'(DEPTH))

endmodule

FILE: rtl/cmad_back.sv
// Divider back end: 16*(x*cnt - sum)/cnt, rounded half away from zero, clamped.
`include "centered_moving_average_detrend_defines.svh"

module cmad_back import cmad_pkg::*; #(
    parameter int HALF_WINDOW = DEF_HALF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int WIN_LEN = 2 * HALF_WINDOW + 1,
    localparam int SB      = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W,
    localparam int CW      = $clog2(WIN_LEN + 1),
    localparam int SUMW    = SB + CW,
    localparam int JOB_W   = SB + SUMW + CW + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  logic [JOB_W-1:0] job,
    cmad_out_if.source       results
);

    localparam int DIGITS = 4;
    localparam int MAGW   = SB + CW;
    localparam int DIFW   = MAGW + 1;
    localparam int DW     = MAGW + FRAC_BITS + 2;
    localparam int NITER  = (DW + DIGITS - 1) / DIGITS;
    localparam int DPW    = NITER * DIGITS;
    localparam int SW     = $clog2(NITER);
    localparam int QW     = (DPW > OUT_W + 1) ? DPW : OUT_W + 1;

    localparam logic [OUT_W-1:0] OUT_MAX_CODE = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN_CODE = {1'b1, {(OUT_W - 1){1'b0}}};
    localparam logic [QW-1:0]    Q_POS_LIM    = QW'(OUT_MAX_CODE);
    localparam logic [QW-1:0]    Q_NEG_LIM    = QW'(OUT_MIN_CODE);

    typedef struct packed {
        logic [SB-1:0]   x;
        logic [SUMW-1:0] sum;
        logic [CW-1:0]   cnt;
        logic            is_last;
    } job_t;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_NORM = 5'b00100,
        B_DIV  = 5'b01000,
        B_DONE = 5'b10000
    } state_t;

    state_t                   state_reg;
    job_t                     job_reg;
    logic signed [DIFW-1:0]   diff_reg;
    logic                     neg_reg;
    logic [DPW-1:0]           dvd_reg, quo_reg;
    logic [CW:0]              dvs_reg;
    logic [CW+1:0]            rem_reg;
    logic [SW-1:0]            step_reg;
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         det_reg;
    logic                     fin_reg;

    logic [MAGW-1:0]          prod, mag;
    logic [CW+1:0]            div_rem;
    logic [DPW-1:0]           div_dvd, div_quo;
    logic [QW-1:0]            qx;
    logic [OUT_W-1:0]         det_val;
    logic                     load_out;

    assign job_ready = (state_reg == B_IDLE);
    assign prod      = MAGW'(job_reg.x) * MAGW'(job_reg.cnt);
    assign mag       = diff_reg[DIFW-1] ? MAGW'(-diff_reg) : MAGW'(diff_reg);

    // Restoring division, DIGITS quotient bits per cycle
    always_comb
    begin
        div_rem = rem_reg;
        div_dvd = dvd_reg;
        div_quo = quo_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            div_rem = {div_rem[CW:0], div_dvd[DPW-1]};
            div_dvd = {div_dvd[DPW-2:0], 1'b0};
            if (div_rem >= (CW + 2)'(dvs_reg))
            begin
                div_rem = div_rem - (CW + 2)'(dvs_reg);
                div_quo = {div_quo[DPW-2:0], 1'b1};
            end
            else
            begin
                div_quo = {div_quo[DPW-2:0], 1'b0};
            end
        end
    end

    // Sign and clamp to the output range
    assign qx = QW'(quo_reg);
    always_comb
    begin
        if (!neg_reg)
        begin
            det_val = (qx > Q_POS_LIM) ? OUT_MAX_CODE : OUT_W'(qx);
        end
        else
        begin
            det_val = (qx > Q_NEG_LIM) ? OUT_MIN_CODE : OUT_W'(~qx + QW'(1));
        end
    end

    assign load_out = (state_reg == B_DONE) && (!out_valid_reg || results.ready);

    // Sequencer and output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    state_reg <= B_NORM;
                end
                B_NORM:
                begin
                    step_reg  <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(NITER - 1))
                    begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && job_valid)
        begin
            job_reg <= job_t'(job);
        end
        if (state_reg == B_MUL)
        begin
            diff_reg <= $signed({1'b0, prod}) - $signed({1'b0, job_reg.sum});
        end
        if (state_reg == B_NORM)
        begin
            neg_reg <= diff_reg[DIFW-1];
            dvd_reg <= DPW'({mag, {(FRAC_BITS + 1){1'b0}}}) + DPW'(job_reg.cnt);
            dvs_reg <= {job_reg.cnt, 1'b0};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (state_reg == B_DIV)
        begin
            dvd_reg <= div_dvd;
            rem_reg <= div_rem;
            quo_reg <= div_quo;
        end
        if (load_out)
        begin
            det_reg <= det_val;
            fin_reg <= job_reg.is_last;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.detrended    = det_reg;
    assign results.final_result = fin_reg;

    `CMAD_ASSERT(a_rem_below_divisor, state_reg != B_DIV || rem_reg < (CW + 2)'(dvs_reg))
    `CMAD_ASSERT_NEXT(a_done_loads_output, load_out, results.valid && state_reg == B_IDLE)

endmodule

FILE: rtl/centered_moving_average_detrend.sv
// Top level of the centered moving average detrend block.
//
//   channel   dir  beat payload                         accepted when
//   samples   in   sample[15:0], end_of_spectrum        valid && ready
//   results   out  detrended[20:0] (s, 4 frac), final   valid && ready
//
// The front end takes a sample with a memory read, then a write that waits on a
// full job queue. The divider takes a job through MUL, NORM, DIV (4 quotient
// bits per cycle) and DONE before the next; at the default window of 31 that
// sets the rate. An end-of-spectrum beat flushes up to HALF_WINDOW+1 results
// into the job queue; no new sample is taken until the flush has been issued.
// Reset clears all control state at once; the window memory needs no clearing.
// Either side may stall; the job queue and the output register decouple them.
module centered_moving_average_detrend import cmad_pkg::*; #(
    parameter int HALF_WINDOW = DEF_HALF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    cmad_in_if.sink    samples,
    cmad_out_if.source results
);

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int SB      = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CW      = $clog2(WIN_LEN + 1);
    localparam int JOB_W   = SB + (SB + CW) + CW + 1;

    logic             fe_valid, fe_ready;
    logic [JOB_W-1:0] fe_job;
    logic             be_valid, be_ready;
    logic [JOB_W-1:0] be_job;

    cmad_front #(
        .HALF_WINDOW (HALF_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .job_valid (fe_valid),
        .job_ready (fe_ready),
        .job       (fe_job)
    );

    cmad_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (fe_job),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_data  (be_job)
    );

    cmad_back #(
        .HALF_WINDOW (HALF_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (be_valid),
        .job_ready (be_ready),
        .job       (be_job),
        .results   (results)
    );

endmodule
